/* hdl/mosaic_block_averager_defines.svh */
// assertion macros shared by the mosaic block averager rtl
`ifndef MOSAIC_BLOCK_AVERAGER_DEFINES_SVH
`define MOSAIC_BLOCK_AVERAGER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define MBA_ASSERT(label, prop, msg)
`define MBA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* hdl/mba_pkg.sv */
`default_nettype none

package mba_pkg;

  localparam int BLOCK      = 4;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int TILE_COLS  = (MAX_WIDTH + BLOCK - 1) / BLOCK;

  localparam int PIX_W     = 8;
  localparam int OUT_ROW_W = 12;
  localparam int OUT_COL_W = 10;
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int HDIM_W    = ROW_W + 1;
  localparam int WDIM_W    = COL_W + 1;
  localparam int OFS_W     = (BLOCK > 2) ? $clog2(BLOCK) : 1;
  localparam int TSZ_W     = $clog2(BLOCK + 1);
  localparam int AREA_W    = $clog2(BLOCK * BLOCK + 1);
  localparam int SUM_W     = $clog2(BLOCK * BLOCK * 256) + 1;
  localparam int TCOL_W    = $clog2(TILE_COLS);
  localparam int DCNT_W    = $clog2(SUM_W);

  localparam int JOB_DEPTH = 4;
  localparam int JPTR_W    = $clog2(JOB_DEPTH);
  localparam int JCNT_W    = $clog2(JOB_DEPTH + 1);

  localparam int CFG_WREG_W = 11;
  localparam int CFG_HREG_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0]  CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_IMAGE_HEIGHT = 1'd1;
  localparam logic [CFG_WREG_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [CFG_HREG_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } mba_in_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] pixel_row;
    logic [OUT_COL_W-1:0] pixel_col;
    logic [PIX_W-1:0]     avg_red;
    logic [PIX_W-1:0]     avg_green;
    logic [PIX_W-1:0]     avg_blue;
    logic                 tile_last;
    logic                 frame_done;
  } mba_out_t;

  typedef struct packed {
    sum_t red;
    sum_t green;
    sum_t blue;
  } mba_sums_t;

  localparam int SUMS_W = $bits(mba_sums_t);

  typedef struct packed {
    logic [ROW_W-1:0] r0;
    logic [COL_W-1:0] c0;
    logic [TSZ_W-1:0] th;
    logic [TSZ_W-1:0] tw;
    logic             frame_last;
    mba_sums_t        sums;
  } mba_job_t;

endpackage

`default_nettype wire

/* hdl/mba_ram.sv */
`default_nettype none

module mba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [ADDR_W-1:0]        raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/mba_front.sv */
`default_nettype none

module mba_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [mba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mba_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire mba_pkg::mba_in_t                in_data,
  input  wire logic [mba_pkg::JCNT_W-1:0]      job_count,
  output      logic                            job_push,
  output      mba_pkg::mba_job_t               job_data
);

  `include "mosaic_block_averager_defines.svh"

  logic [mba_pkg::CFG_WREG_W-1:0] cfg_width_r;
  logic [mba_pkg::CFG_HREG_W-1:0] cfg_height_r;
  logic [mba_pkg::WDIM_W-1:0]     dim_w;
  logic [mba_pkg::HDIM_W-1:0]     dim_h;

  logic [mba_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [mba_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [mba_pkg::OFS_W-1:0]  rof_r, rof_nxt;
  logic [mba_pkg::OFS_W-1:0]  cof_r, cof_nxt;
  logic [mba_pkg::TCOL_W-1:0] tcol_r, tcol_nxt;

  logic                       wrap_c, wrap_r, col_end, row_end, cof_end, rof_end;
  logic [mba_pkg::COL_W-1:0]  col0;
  logic [mba_pkg::OFS_W-1:0]  cof0, rof1, rof0;
  logic [mba_pkg::TCOL_W-1:0] tcol0;
  logic [mba_pkg::HDIM_W-1:0] row1;
  logic [mba_pkg::ROW_W-1:0]  row0;
  logic                       accept;

  logic                       s1_valid_r;
  mba_pkg::mba_in_t           s1_pix_r;
  logic [mba_pkg::ROW_W-1:0]  s1_row_r;
  logic [mba_pkg::COL_W-1:0]  s1_col_r;
  logic [mba_pkg::OFS_W-1:0]  s1_rof_r;
  logic [mba_pkg::OFS_W-1:0]  s1_cof_r;
  logic [mba_pkg::TCOL_W-1:0] s1_tcol_r;
  logic                       s1_load_r;
  logic                       s1_done_r;
  logic                       s1_flast_r;
  logic                       fwd_hit_r;
  mba_pkg::mba_sums_t         fwd_sums_r;

  logic [mba_pkg::SUMS_W-1:0] ram_rdata;
  mba_pkg::mba_sums_t         base_sums;
  mba_pkg::mba_sums_t         new_sums;

  function automatic logic [mba_pkg::OFS_W-1:0] ofs_inc(input logic [mba_pkg::OFS_W-1:0] o);
    return (o == mba_pkg::OFS_W'(mba_pkg::BLOCK - 1)) ? '0 : o + mba_pkg::OFS_W'(1);
  endfunction

  function automatic mba_pkg::sum_t sat_add(input mba_pkg::sum_t s,
                                            input logic [mba_pkg::PIX_W-1:0] p);
    logic [mba_pkg::SUM_W:0] t;
    t = {1'b0, s} + {{(mba_pkg::SUM_W + 1 - mba_pkg::PIX_W){1'b0}}, p};
    return t[mba_pkg::SUM_W] ? '1 : t[mba_pkg::SUM_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= mba_pkg::IMAGE_WIDTH_RST;
      cfg_height_r <= mba_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mba_pkg::CFG_IMAGE_WIDTH:  cfg_width_r  <= cfg_data[mba_pkg::CFG_WREG_W-1:0];
        mba_pkg::CFG_IMAGE_HEIGHT: cfg_height_r <= cfg_data[mba_pkg::CFG_HREG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    if (cfg_width_r == '0) begin
      dim_w = mba_pkg::WDIM_W'(1);
    end else if (int'(cfg_width_r) > mba_pkg::MAX_WIDTH) begin
      dim_w = mba_pkg::WDIM_W'(mba_pkg::MAX_WIDTH);
    end else begin
      dim_w = mba_pkg::WDIM_W'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      dim_h = mba_pkg::HDIM_W'(1);
    end else if (int'(cfg_height_r) > mba_pkg::MAX_HEIGHT) begin
      dim_h = mba_pkg::HDIM_W'(mba_pkg::MAX_HEIGHT);
    end else begin
      dim_h = mba_pkg::HDIM_W'(cfg_height_r);
    end
  end

  assign in_stall = ({1'b0, job_count} + {{mba_pkg::JCNT_W{1'b0}}, s1_valid_r})
                    >= (mba_pkg::JCNT_W + 1)'(mba_pkg::JOB_DEPTH);
  assign accept   = in_valid && !in_stall;

  // raster position of the incoming pixel
  always_comb begin
    wrap_c  = {1'b0, col_r} >= dim_w;
    col0    = wrap_c ? '0 : col_r;
    cof0    = wrap_c ? '0 : cof_r;
    tcol0   = wrap_c ? '0 : tcol_r;
    row1    = {1'b0, row_r} + mba_pkg::HDIM_W'(wrap_c);
    rof1    = wrap_c ? ofs_inc(rof_r) : rof_r;
    wrap_r  = row1 >= dim_h;
    row0    = wrap_r ? '0 : row1[mba_pkg::ROW_W-1:0];
    rof0    = wrap_r ? '0 : rof1;
    col_end = ({1'b0, col0} + mba_pkg::WDIM_W'(1)) >= dim_w;
    row_end = ({1'b0, row0} + mba_pkg::HDIM_W'(1)) >= dim_h;
    cof_end = cof0 == mba_pkg::OFS_W'(mba_pkg::BLOCK - 1);
    rof_end = rof0 == mba_pkg::OFS_W'(mba_pkg::BLOCK - 1);

    row_nxt  = row_r;
    col_nxt  = col_r;
    rof_nxt  = rof_r;
    cof_nxt  = cof_r;
    tcol_nxt = tcol_r;
    if (accept) begin
      if (col_end) begin
        col_nxt  = '0;
        cof_nxt  = '0;
        tcol_nxt = '0;
        if (row_end) begin
          row_nxt = '0;
          rof_nxt = '0;
        end else begin
          row_nxt = row0 + mba_pkg::ROW_W'(1);
          rof_nxt = ofs_inc(rof0);
        end
      end else begin
        row_nxt  = row0;
        rof_nxt  = rof0;
        col_nxt  = col0 + mba_pkg::COL_W'(1);
        cof_nxt  = ofs_inc(cof0);
        tcol_nxt = cof_end ? tcol0 + mba_pkg::TCOL_W'(1) : tcol0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      rof_r      <= '0;
      cof_r      <= '0;
      tcol_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      rof_r      <= rof_nxt;
      cof_r      <= cof_nxt;
      tcol_r     <= tcol_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= in_data;
      s1_row_r   <= row0;
      s1_col_r   <= col0;
      s1_rof_r   <= rof0;
      s1_cof_r   <= cof0;
      s1_tcol_r  <= tcol0;
      s1_load_r  <= (rof0 == '0) && (cof0 == '0);
      s1_done_r  <= (rof_end || row_end) && (cof_end || col_end);
      s1_flast_r <= row_end && col_end;
    end
    // back-to-back pixels of one tile column see the sum written this edge
    fwd_hit_r  <= s1_valid_r && (s1_tcol_r == tcol0);
    fwd_sums_r <= new_sums;
  end

  mba_ram #(
    .WIDTH (mba_pkg::SUMS_W),
    .DEPTH (mba_pkg::TILE_COLS)
  ) u_sum_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_tcol_r),
    .wdata (new_sums),
    .re    (accept),
    .raddr (tcol0),
    .rdata (ram_rdata)
  );

  always_comb begin
    base_sums = fwd_hit_r ? fwd_sums_r : mba_pkg::mba_sums_t'(ram_rdata);
    if (s1_load_r) begin
      new_sums.red   = mba_pkg::SUM_W'(s1_pix_r.red_in);
      new_sums.green = mba_pkg::SUM_W'(s1_pix_r.green_in);
      new_sums.blue  = mba_pkg::SUM_W'(s1_pix_r.blue_in);
    end else begin
      new_sums.red   = sat_add(base_sums.red, s1_pix_r.red_in);
      new_sums.green = sat_add(base_sums.green, s1_pix_r.green_in);
      new_sums.blue  = sat_add(base_sums.blue, s1_pix_r.blue_in);
    end
  end

  assign job_push            = s1_valid_r && s1_done_r;
  assign job_data.r0         = s1_row_r - mba_pkg::ROW_W'(s1_rof_r);
  assign job_data.c0         = s1_col_r - mba_pkg::COL_W'(s1_cof_r);
  assign job_data.th         = mba_pkg::TSZ_W'(s1_rof_r) + mba_pkg::TSZ_W'(1);
  assign job_data.tw         = mba_pkg::TSZ_W'(s1_cof_r) + mba_pkg::TSZ_W'(1);
  assign job_data.frame_last = s1_flast_r;
  assign job_data.sums       = new_sums;

  `MBA_ASSERT(a_fwd_needs_prev, s1_valid_r && fwd_hit_r |-> $past(s1_valid_r), "forward without prior write")

endmodule

`default_nettype wire

/* hdl/mba_job_fifo.sv */
`default_nettype none

module mba_job_fifo (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire mba_pkg::mba_job_t           push_data,
  input  wire logic                        pop,
  output      mba_pkg::mba_job_t           head,
  output      logic [mba_pkg::JCNT_W-1:0]  count
);

  `include "mosaic_block_averager_defines.svh"

  mba_pkg::mba_job_t             mem_r [mba_pkg::JOB_DEPTH];
  logic [mba_pkg::JPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [mba_pkg::JPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [mba_pkg::JCNT_W-1:0]    count_r, count_nxt;

  function automatic logic [mba_pkg::JPTR_W-1:0] ptr_inc(input logic [mba_pkg::JPTR_W-1:0] p);
    return (p == mba_pkg::JPTR_W'(mba_pkg::JOB_DEPTH - 1)) ? '0 : p + mba_pkg::JPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + mba_pkg::JCNT_W'(push) - mba_pkg::JCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

  `MBA_ASSERT(a_no_overflow, push |-> count_r != mba_pkg::JCNT_W'(mba_pkg::JOB_DEPTH), "tile queue overflow")
  `MBA_ASSERT(a_no_underflow, pop |-> count_r != '0, "tile queue underflow")

endmodule

`default_nettype wire

/* hdl/mba_back.sv */
`default_nettype none

module mba_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [mba_pkg::JCNT_W-1:0]  job_count,
  input  wire mba_pkg::mba_job_t           job_data,
  output      logic                        job_pop,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      mba_pkg::mba_out_t           out_data
);

  `include "mosaic_block_averager_defines.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } mba_state_t;

  mba_state_t                  state_r, state_nxt;
  mba_pkg::mba_job_t           job_r, job_nxt;
  logic [mba_pkg::AREA_W-1:0]  area_r, area_nxt;
  logic [mba_pkg::DCNT_W-1:0]  cnt_r, cnt_nxt;
  mba_pkg::sum_t               dq_r [3];
  mba_pkg::sum_t               dq_nxt [3];
  mba_pkg::sum_t               dq_stp [3];
  logic [mba_pkg::AREA_W-1:0]  rem_r [3];
  logic [mba_pkg::AREA_W-1:0]  rem_nxt [3];
  logic [mba_pkg::AREA_W-1:0]  rem_stp [3];
  logic [mba_pkg::PIX_W-1:0]   avg_r [3];
  logic [mba_pkg::PIX_W-1:0]   avg_nxt [3];
  logic [mba_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [mba_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [mba_pkg::OFS_W-1:0]   i_r, i_nxt;
  logic [mba_pkg::OFS_W-1:0]   j_r, j_nxt;
  logic                        i_last, j_last;

  // one restoring quotient bit
  function automatic logic [mba_pkg::AREA_W+mba_pkg::SUM_W-1:0] div_step(
    input logic [mba_pkg::AREA_W-1:0] rem,
    input mba_pkg::sum_t              dq,
    input logic [mba_pkg::AREA_W-1:0] d
  );
    logic [mba_pkg::AREA_W:0] trial;
    logic                     qbit;
    trial = {rem, dq[mba_pkg::SUM_W-1]};
    qbit  = trial >= {1'b0, d};
    if (qbit) begin
      trial = trial - {1'b0, d};
    end
    return {trial[mba_pkg::AREA_W-1:0], dq[mba_pkg::SUM_W-2:0], qbit};
  endfunction

  function automatic logic [mba_pkg::PIX_W-1:0] clamp8(input mba_pkg::sum_t q);
    return (q > mba_pkg::SUM_W'(255)) ? '1 : q[mba_pkg::PIX_W-1:0];
  endfunction

  assign i_last = (mba_pkg::TSZ_W'(i_r) + mba_pkg::TSZ_W'(1)) == job_r.th;
  assign j_last = (mba_pkg::TSZ_W'(j_r) + mba_pkg::TSZ_W'(1)) == job_r.tw;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    area_nxt  = area_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    job_pop   = 1'b0;
    for (int c = 0; c < 3; c++) begin
      dq_nxt[c]  = dq_r[c];
      rem_nxt[c] = rem_r[c];
      avg_nxt[c] = avg_r[c];
      {rem_stp[c], dq_stp[c]} = div_step(rem_r[c], dq_r[c], area_r);
    end
    unique case (state_r)
      ST_IDLE: begin
        if (job_count != '0) begin
          job_pop   = 1'b1;
          job_nxt   = job_data;
          dq_nxt[0] = job_data.sums.red;
          dq_nxt[1] = job_data.sums.green;
          dq_nxt[2] = job_data.sums.blue;
          for (int c = 0; c < 3; c++) begin
            rem_nxt[c] = '0;
          end
          area_nxt  = mba_pkg::AREA_W'(job_data.th) * mba_pkg::AREA_W'(job_data.tw);
          cnt_nxt   = mba_pkg::DCNT_W'(mba_pkg::SUM_W - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        for (int c = 0; c < 3; c++) begin
          dq_nxt[c]  = dq_stp[c];
          rem_nxt[c] = rem_stp[c];
        end
        if (cnt_r == '0) begin
          for (int c = 0; c < 3; c++) begin
            avg_nxt[c] = clamp8(dq_stp[c]);
          end
          row_nxt   = job_r.r0;
          col_nxt   = job_r.c0;
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r - mba_pkg::DCNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          if (i_last && j_last) begin
            state_nxt = ST_IDLE;
          end else if (j_last) begin
            j_nxt   = '0;
            col_nxt = job_r.c0;
            i_nxt   = i_r + mba_pkg::OFS_W'(1);
            row_nxt = row_r + mba_pkg::ROW_W'(1);
          end else begin
            j_nxt   = j_r + mba_pkg::OFS_W'(1);
            col_nxt = col_r + mba_pkg::COL_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    area_r <= area_nxt;
    cnt_r  <= cnt_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    for (int c = 0; c < 3; c++) begin
      dq_r[c]  <= dq_nxt[c];
      rem_r[c] <= rem_nxt[c];
      avg_r[c] <= avg_nxt[c];
    end
  end

  assign out_valid           = state_r == ST_EMIT;
  assign out_data.pixel_row  = mba_pkg::OUT_ROW_W'(row_r);
  assign out_data.pixel_col  = mba_pkg::OUT_COL_W'(col_r);
  assign out_data.avg_red    = avg_r[0];
  assign out_data.avg_green  = avg_r[1];
  assign out_data.avg_blue   = avg_r[2];
  assign out_data.tile_last  = i_last && j_last;
  assign out_data.frame_done = i_last && j_last && job_r.frame_last;

  `MBA_ASSERT_NEXT(a_last_ends_tile, out_valid && !out_stall && out_data.tile_last, state_r == ST_IDLE, "tile did not end after last pixel")
  `MBA_ASSERT_NEXT(a_div_moves_on, state_r == ST_DIV, state_r == ST_DIV || state_r == ST_EMIT, "divider left early")

endmodule

`default_nettype wire

/* hdl/mosaic_block_averager.sv */
// channel   dir  handshake          payload
// in        in   in_valid/in_stall  in_data    (mba_in_t: red, green, blue)
// out       out  out_valid/out_stall out_data  (mba_out_t: row, col, averages, flags)
// cfg       in   cfg_we             cfg_index, cfg_data (width, height)
//
// the front takes one pixel per cycle while in_stall is low: sum read, add and write-back of the tile
// column run as a two-stage pipeline with forwarding
// the back pops a completed tile, then runs the divider at one quotient bit per
// cycle and emits one transaction per pixel of the tile
// a 4-entry tile queue sits between them; in_stall rises when the queue plus the
// tile in flight would fill it, out_stall only holds the back
// synchronous active-low reset clears counters, queue and state; sums are not cleared
`default_nettype none

module mosaic_block_averager (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [mba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mba_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire mba_pkg::mba_in_t                in_data,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      mba_pkg::mba_out_t               out_data
);

  logic                        job_push;
  logic                        job_pop;
  mba_pkg::mba_job_t           job_in;
  mba_pkg::mba_job_t           job_head;
  logic [mba_pkg::JCNT_W-1:0]  job_count;

  mba_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_count (job_count),
    .job_push  (job_push),
    .job_data  (job_in)
  );

  mba_job_fifo u_job_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .head      (job_head),
    .count     (job_count)
  );

  mba_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_count (job_count),
    .job_data  (job_head),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
